// ===== hdl/zbsfw_pkg.sv =====
// zbsfw_pkg: shared types, constants and arithmetic step functions for the
// depth-tested shaded frame store. no dependencies.
package zbsfw_pkg;

  localparam int MAX_COLUMNS = 512;
  localparam int MAX_ROWS    = 512;
  localparam int COL_W       = $clog2(MAX_COLUMNS);
  localparam int ROW_W       = $clog2(MAX_ROWS);
  localparam int ADDR_W      = COL_W + ROW_W;
  localparam int PIXELS      = MAX_COLUMNS * MAX_ROWS;

  localparam logic [31:0] FULL_DEPTH  = 32'hFFFF_FFFF;
  localparam logic [14:0] COS_ONE     = 15'd16384;
  localparam logic [14:0] COS_HALF    = 15'd8192;
  localparam logic [7:0]  CHANNEL_MAX = 8'd255;

  typedef enum logic [1:0] {
    OP_CLEAR    = 2'd0,
    OP_FRAGMENT = 2'd1,
    OP_READ     = 2'd2,
    OP_UNUSED   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    CFG_LIGHT_X    = 3'd0,
    CFG_LIGHT_Y    = 3'd1,
    CFG_LIGHT_Z    = 3'd2,
    CFG_BACKGROUND = 3'd3,
    CFG_COLUMNS    = 3'd4,
    CFG_ROWS       = 3'd5
  } cfg_index_t;

  typedef struct packed {
    op_t                op;
    logic [8:0]         column;
    logic [8:0]         row;
    logic [31:0]        distance;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic [7:0]         base_red;
    logic [7:0]         base_green;
    logic [7:0]         base_blue;
  } in_word_t;

  typedef struct packed {
    logic       written;
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
  } out_word_t;

  typedef struct packed {
    logic signed [15:0] light_x;
    logic signed [15:0] light_y;
    logic signed [15:0] light_z;
    logic [23:0]        background_rgb;
    logic [9:0]         columns_in_use;
    logic [9:0]         rows_in_use;
  } cfg_t;

  typedef struct packed {
    op_t               op;
    logic              in_image;
    logic [ADDR_W-1:0] addr;
    logic [31:0]       distance;
    logic [23:0]       rgb;
  } job_t;

  typedef struct packed {
    logic empty;
    logic full;
  } fifo_status_t;

  typedef enum logic [2:0] {
    F_IDLE, F_PROD, F_SUM, F_MULT, F_SQRT, F_DIV, F_SHADE, F_PUSH
  } front_state_t;

  typedef enum logic {
    B_IDLE, B_EXEC
  } back_state_t;

  typedef struct packed {
    logic [63:0] rad;
    logic [35:0] rem;
    logic [31:0] root;
  } sqrt_t;

  typedef struct packed {
    logic [46:0] rem;
    logic [46:0] dsh;
    logic [15:0] quo;
  } div_t;

  // one digit of the restoring square root
  function automatic sqrt_t sqrt_step(sqrt_t s);
    sqrt_t       r;
    logic [35:0] cur;
    logic [35:0] trial;
    cur   = {s.rem[33:0], s.rad[63:62]};
    trial = {2'b00, s.root, 2'b01};
    r.rad = {s.rad[61:0], 2'b00};
    if (cur >= trial) begin
      r.rem  = cur - trial;
      r.root = {s.root[30:0], 1'b1};
    end else begin
      r.rem  = cur;
      r.root = {s.root[30:0], 1'b0};
    end
    return r;
  endfunction

  // one quotient bit of the restoring division
  function automatic div_t div_step(div_t d);
    div_t r;
    r.dsh = {1'b0, d.dsh[46:1]};
    if (d.rem >= d.dsh) begin
      r.rem = d.rem - d.dsh;
      r.quo = {d.quo[14:0], 1'b1};
    end else begin
      r.rem = d.rem;
      r.quo = {d.quo[14:0], 1'b0};
    end
    return r;
  endfunction

  // half base plus diffuse ramp, towards white above cos one half
  function automatic logic [7:0] shade_channel(logic [7:0] b, logic [14:0] c);
    logic [24:0] acc;
    logic [10:0] v;
    if (c <= COS_HALF) begin
      acc = 25'(b) * (25'(c) + 25'(COS_HALF));
    end else begin
      acc = {4'b0, b, 13'b0}
          + 25'(CHANNEL_MAX) * (25'(c) - 25'(COS_HALF))
          + 25'(b) * (25'(COS_ONE) - 25'(c));
    end
    v = acc[24:14];
    return (v > 11'(CHANNEL_MAX)) ? CHANNEL_MAX : v[7:0];
  endfunction

endpackage

// ===== hdl/zbsfw_ram.sv =====
// zbsfw_ram: generic simple dual port ram with registered read.
// no dependencies.
module zbsfw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/zbsfw_front.sv =====
// zbsfw_front: accepts words, classifies them and works out the shaded
// colour of fragments. depends on zbsfw_pkg.
module zbsfw_front (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  zbsfw_pkg::in_word_t    item,
  input  zbsfw_pkg::cfg_t        cfg,
  input  zbsfw_pkg::fifo_status_t fifo_st,
  output logic                   busy,
  output logic                   push,
  output zbsfw_pkg::job_t        job
);
  import zbsfw_pkg::*;

  front_state_t state, state_next;
  in_word_t     item_q;
  job_t         job_q;

  logic signed [31:0] lxnx, lyny, lznz, lxx, lyy, lzz, nxx, nyy, nzz;
  logic signed [33:0] dot;
  logic [31:0]        ll, nn, num;
  sqrt_t              sq, sq_next;
  div_t               dv, dv_next;
  logic [14:0]        cos;
  logic [3:0]         step;

  logic [9:0]  rows_lim;
  logic [9:0]  flip;
  logic        in_image;

  assign sq_next = sqrt_step(sqrt_step(sq));
  assign dv_next = div_step(div_step(dv));

  // classification of the incoming word
  always_comb begin
    rows_lim = (cfg.rows_in_use > 10'(MAX_ROWS)) ? 10'(MAX_ROWS) : cfg.rows_in_use;
    flip     = rows_lim - 10'd1 - {1'b0, item.row};
    in_image = ({1'b0, item.column} < cfg.columns_in_use)
            && ({1'b0, item.row} < cfg.rows_in_use);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      F_IDLE: begin
        if (start) begin
          item_q          <= item;
          job_q.op        <= item.op;
          job_q.in_image  <= in_image && (item.op != OP_UNUSED);
          job_q.distance  <= item.distance;
          job_q.addr      <= (item.op == OP_READ) ? {flip[ROW_W-1:0], item.column}
                                                  : {item.row, item.column};
          job_q.rgb       <= (item.op == OP_CLEAR && in_image) ? cfg.background_rgb
                                                               : 24'd0;
        end
      end
      F_PROD: begin
        lxnx <= 32'(cfg.light_x) * 32'(item_q.normal_x);
        lyny <= 32'(cfg.light_y) * 32'(item_q.normal_y);
        lznz <= 32'(cfg.light_z) * 32'(item_q.normal_z);
        lxx  <= 32'(cfg.light_x) * 32'(cfg.light_x);
        lyy  <= 32'(cfg.light_y) * 32'(cfg.light_y);
        lzz  <= 32'(cfg.light_z) * 32'(cfg.light_z);
        nxx  <= 32'(item_q.normal_x) * 32'(item_q.normal_x);
        nyy  <= 32'(item_q.normal_y) * 32'(item_q.normal_y);
        nzz  <= 32'(item_q.normal_z) * 32'(item_q.normal_z);
      end
      F_SUM: begin
        dot <= 34'(lxnx) + 34'(lyny) + 34'(lznz);
        ll  <= $unsigned(lxx) + $unsigned(lyy) + $unsigned(lzz);
        nn  <= $unsigned(nxx) + $unsigned(nyy) + $unsigned(nzz);
      end
      F_MULT: begin
        sq.rad  <= ll * nn;
        sq.rem  <= '0;
        sq.root <= '0;
        num     <= 32'(-dot);
        cos     <= '0;
        step    <= '0;
      end
      F_SQRT: begin
        sq   <= sq_next;
        step <= step + 4'd1;
        if (step == 4'd15) begin
          dv.rem <= {1'b0, num, 14'b0};
          dv.dsh <= {sq_next.root, 15'b0};
          dv.quo <= '0;
        end
      end
      F_DIV: begin
        dv   <= dv_next;
        step <= step + 4'd1;
        if (step == 4'd7) begin
          cos <= (dv_next.quo > 16'(COS_ONE)) ? COS_ONE : dv_next.quo[14:0];
        end
      end
      F_SHADE: begin
        job_q.rgb <= {shade_channel(item_q.base_red, cos),
                      shade_channel(item_q.base_green, cos),
                      shade_channel(item_q.base_blue, cos)};
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      F_IDLE:  if (start) state_next = (item.op == OP_FRAGMENT) ? F_PROD : F_PUSH;
      F_PROD:  state_next = F_SUM;
      F_SUM:   state_next = F_MULT;
      F_MULT:  state_next = dot[33] ? F_SQRT : F_SHADE;
      F_SQRT:  if (step == 4'd15) state_next = F_DIV;
      F_DIV:   if (step == 4'd7) state_next = F_SHADE;
      F_SHADE: state_next = F_PUSH;
      F_PUSH:  if (!fifo_st.full) state_next = F_IDLE;
      default: state_next = F_IDLE;
    endcase
  end

  always_comb begin
    busy = (state != F_IDLE);
    push = (state == F_PUSH) && !fifo_st.full;
    job  = job_q;
  end

endmodule

// ===== hdl/zbsfw_fifo.sv =====
// zbsfw_fifo: two entry queue of jobs between front and back.
// depends on zbsfw_pkg.
module zbsfw_fifo (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  zbsfw_pkg::job_t         wdata,
  input  logic                    pop,
  output zbsfw_pkg::job_t         rdata,
  output zbsfw_pkg::fifo_status_t st
);
  import zbsfw_pkg::*;

  job_t       entry [2];
  logic       wptr, rptr;
  logic [1:0] count;

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop)  rptr <= ~rptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  assign rdata    = entry[rptr];
  assign st.empty = (count == 2'd0);
  assign st.full  = (count == 2'd2);

endmodule

// ===== hdl/zbsfw_back.sv =====
// zbsfw_back: carries out jobs against the depth and colour stores and
// drives the result word. depends on zbsfw_pkg and zbsfw_ram.
module zbsfw_back (
  input  logic                    clk,
  input  logic                    rst,
  input  zbsfw_pkg::job_t         head,
  input  zbsfw_pkg::fifo_status_t fifo_st,
  output logic                    pop,
  output logic                    result_valid,
  output zbsfw_pkg::out_word_t    result
);
  import zbsfw_pkg::*;

  back_state_t state, state_next;
  job_t        job_q;
  logic [31:0] depth_rd, depth_wr;
  logic [23:0] color_rd, out_rgb;
  logic        we;

  zbsfw_ram #(.WIDTH(32), .DEPTH(PIXELS)) u_depth (
    .clk(clk), .we(we), .waddr(job_q.addr), .wdata(depth_wr),
    .raddr(head.addr), .rdata(depth_rd)
  );

  zbsfw_ram #(.WIDTH(24), .DEPTH(PIXELS)) u_color (
    .clk(clk), .we(we), .waddr(job_q.addr), .wdata(job_q.rgb),
    .raddr(head.addr), .rdata(color_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      B_IDLE:  if (!fifo_st.empty) state_next = B_EXEC;
      B_EXEC:  state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  always_comb begin
    pop      = (state == B_IDLE) && !fifo_st.empty;
    we       = 1'b0;
    depth_wr = job_q.distance;
    out_rgb  = job_q.rgb;
    if (state == B_EXEC) begin
      case (job_q.op)
        OP_CLEAR: begin
          we       = job_q.in_image;
          depth_wr = FULL_DEPTH;
        end
        OP_FRAGMENT: we = job_q.in_image && (job_q.distance < depth_rd);
        OP_READ:     out_rgb = job_q.in_image ? color_rd : 24'd0;
        default:     we = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      job_q <= head;
    end
    if (state == B_EXEC) begin
      result <= '{written: we, out_red: out_rgb[23:16], out_green: out_rgb[15:8],
                  out_blue: out_rgb[7:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= (state == B_EXEC);
    end
  end

endmodule

// ===== hdl/zbuffer_shaded_fragment_writer_core.sv =====
// zbuffer_shaded_fragment_writer_core: top level of the depth-tested shaded
// frame store. depends on zbsfw_pkg, zbsfw_front, zbsfw_fifo, zbsfw_back.
//
//   channel   signals                         moves
//   command   start, busy, item               one input word (clear, fragment, read)
//   result    result_valid, result            one output word, one cycle strobe
//   config    cfg_we, cfg_index, cfg_data     one register write, no wait
//
// a clear, read or unused word goes from acceptance straight to hand-over and
// leaves the front once the queue has room; a fragment holds the front through
// the product, sum and multiply steps, the square root at two bits a cycle, the
// division at two bits a cycle, shading and hand-over, and skips root and
// division when the light does not face the surface and cos is zero.
// the back pops a word and starts the registered store read, then executes it
// before the next pop; the result strobe comes in the cycle after execution.
// rst is synchronous; it clears the sequencers, queue and configuration registers,
// but not the stores, which hold nothing meaningful until a pixel is cleared.
// the receiver cannot stall; busy stays high while the front holds a word.
module zbuffer_shaded_fragment_writer_core (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  zbsfw_pkg::in_word_t  item,
  output logic                 result_valid,
  output zbsfw_pkg::out_word_t result,
  input  logic                 cfg_we,
  input  logic [2:0]           cfg_index,
  input  logic [23:0]          cfg_data
);
  import zbsfw_pkg::*;

  cfg_t         cfg;
  job_t         front_job, head;
  fifo_status_t fifo_st;
  logic         push, pop;

  // configuration registers; the user must write them only while the block is idle, the block does not enforce it
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.light_x        <= 16'sd0;
      cfg.light_y        <= 16'sd0;
      cfg.light_z        <= 16'sd16384;
      cfg.background_rgb <= 24'd0;
      cfg.columns_in_use <= 10'(MAX_COLUMNS);
      cfg.rows_in_use    <= 10'(MAX_ROWS);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_LIGHT_X:    cfg.light_x        <= cfg_data[15:0];
        CFG_LIGHT_Y:    cfg.light_y        <= cfg_data[15:0];
        CFG_LIGHT_Z:    cfg.light_z        <= cfg_data[15:0];
        CFG_BACKGROUND: cfg.background_rgb <= cfg_data;
        CFG_COLUMNS:    cfg.columns_in_use <= cfg_data[9:0];
        CFG_ROWS:       cfg.rows_in_use    <= cfg_data[9:0];
        default:        cfg.light_x        <= cfg.light_x;
      endcase
    end
  end

  // front: acceptance, pixel classification and shading
  zbsfw_front u_front (
    .clk(clk), .rst(rst), .start(start), .item(item), .cfg(cfg),
    .fifo_st(fifo_st), .busy(busy), .push(push), .job(front_job)
  );

  // short queue so that front and back stall independently
  zbsfw_fifo u_fifo (
    .clk(clk), .rst(rst), .push(push), .wdata(front_job),
    .pop(pop), .rdata(head), .st(fifo_st)
  );

  // back: depth test, store update and result word
  zbsfw_back u_back (
    .clk(clk), .rst(rst), .head(head), .fifo_st(fifo_st), .pop(pop),
    .result_valid(result_valid), .result(result)
  );

endmodule

// ===== dv/tb_zbuffer_shaded_fragment_writer_core.sv =====
// tb_zbuffer_shaded_fragment_writer_core: self-checking bench for the depth-tested
// shaded frame store; a behavioural predictor of the stores, shading and row flip.
// depends on zbsfw_pkg and zbuffer_shaded_fragment_writer_core.
`timescale 1ns / 100ps
module tb_zbuffer_shaded_fragment_writer_core;
  import zbsfw_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  in_word_t item = '0;
  logic result_valid;
  out_word_t result;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [23:0] cfg_data = '0;

  always #1 clk = ~clk;

  zbuffer_shaded_fragment_writer_core u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item(item),
    .result_valid(result_valid), .result(result),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // predictor state: light, background, image size, and the pixel stores
  logic signed [15:0] lgt_x = 16'sd0, lgt_y = 16'sd0, lgt_z = 16'sd16384;
  logic [23:0] bg_rgb = '0;
  logic [9:0] img_cols = 10'd512, img_rows = 10'd512;
  logic [31:0] depth_mem [int];
  logic [23:0] color_mem [int];

  in_word_t pending_words [$];
  out_word_t expected_words [$];
  int errors = 0;
  int idle_pct = 0;

  // floor root of a product up to about 2^64
  function automatic logic [63:0] isqrt(logic [63:0] v);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic int cosine(logic signed [15:0] nx, logic signed [15:0] ny,
                                logic signed [15:0] nz);
    longint dotp, ll, nn;
    logic [63:0] root, c;
    dotp = longint'(lgt_x) * nx + longint'(lgt_y) * ny + longint'(lgt_z) * nz;
    ll = longint'(lgt_x) * lgt_x + longint'(lgt_y) * lgt_y + longint'(lgt_z) * lgt_z;
    nn = longint'(nx) * nx + longint'(ny) * ny + longint'(nz) * nz;
    root = isqrt(64'(ll) * 64'(nn));
    if (root == 0 || -dotp <= 0) return 0;
    c = (64'(-dotp) << 14) / root;
    return (c > 16384) ? 16384 : int'(c);
  endfunction

  function automatic logic [7:0] shade(logic [7:0] b, int c);
    longint acc;
    if (c <= 0) return b >> 1;
    if (c <= 8192) acc = 8192 * b + b * c;
    else acc = 8192 * b + 255 * (c - 8192) + b * (16384 - c);
    acc = acc >> 14;
    return (acc > 255) ? 8'd255 : acc[7:0];
  endfunction

  function automatic out_word_t frame_store_step(in_word_t w);
    out_word_t o;
    int cols, rows, addr, c;
    bit in_img;
    o = '0;
    cols = (img_cols > 512) ? 512 : img_cols;
    rows = (img_rows > 512) ? 512 : img_rows;
    in_img = (w.column < cols) && (w.row < rows);
    case (w.op)
      OP_READ: if (in_img) begin
        addr = (rows - 1 - w.row) * MAX_COLUMNS + w.column;
        {o.out_red, o.out_green, o.out_blue} = color_mem[addr];
      end
      OP_CLEAR: if (in_img) begin
        addr = w.row * MAX_COLUMNS + w.column;
        depth_mem[addr] = FULL_DEPTH;
        color_mem[addr] = bg_rgb;
        {o.out_red, o.out_green, o.out_blue} = bg_rgb;
        o.written = 1'b1;
      end
      OP_FRAGMENT: begin
        c = cosine(w.normal_x, w.normal_y, w.normal_z);
        o.out_red = shade(w.base_red, c);
        o.out_green = shade(w.base_green, c);
        o.out_blue = shade(w.base_blue, c);
        if (in_img) begin
          addr = w.row * MAX_COLUMNS + w.column;
          if (w.distance < depth_mem[addr]) begin
            depth_mem[addr] = w.distance;
            color_mem[addr] = {o.out_red, o.out_green, o.out_blue};
            o.written = 1'b1;
          end
        end
      end
      default: ;
    endcase
    return o;
  endfunction

  // driver: hold a word on item with start high until accepted
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) begin
        expected_words.push_back(frame_store_step(item));
        void'(pending_words.pop_front());
      end
      if ((!start || !busy) && pending_words.size() > 0) begin
        if ($urandom_range(99) < idle_pct) start <= 1'b0;
        else begin
          start <= 1'b1;
          item <= pending_words[0];
        end
      end else if (start && !busy) begin
        start <= 1'b0;
      end
    end
  end

  // monitor: every strobed word against the oldest expectation
  always @(posedge clk) begin
    out_word_t exp_w;
    if (!rst && result_valid) begin
      if (expected_words.size() == 0) begin
        $error("result word with nothing expected");
        errors++;
      end else begin
        exp_w = expected_words.pop_front();
        if (result.written !== exp_w.written) begin
          $error("written exp %0d got %0d", exp_w.written, result.written); errors++;
        end
        if (result.out_red !== exp_w.out_red) begin
          $error("out_red exp %0d got %0d", exp_w.out_red, result.out_red); errors++;
        end
        if (result.out_green !== exp_w.out_green) begin
          $error("out_green exp %0d got %0d", exp_w.out_green, result.out_green); errors++;
        end
        if (result.out_blue !== exp_w.out_blue) begin
          $error("out_blue exp %0d got %0d", exp_w.out_blue, result.out_blue); errors++;
        end
      end
    end
  end

  task automatic drain();
    while (pending_words.size() != 0 || start || expected_words.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(cfg_index_t idx, logic [23:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_LIGHT_X: lgt_x = val[15:0];
      CFG_LIGHT_Y: lgt_y = val[15:0];
      CFG_LIGHT_Z: lgt_z = val[15:0];
      CFG_BACKGROUND: bg_rgb = val;
      CFG_COLUMNS: img_cols = val[9:0];
      default: img_rows = val[9:0];
    endcase
  endtask

  function automatic in_word_t make_word(op_t op, int col, int row);
    in_word_t w;
    w = '0;
    w.op = op;
    w.column = 9'(col);
    w.row = 9'(row);
    w.distance = $urandom();
    w.normal_x = 16'($urandom());
    w.normal_y = 16'($urandom());
    w.normal_z = 16'($urandom());
    {w.base_red, w.base_green, w.base_blue} = 24'($urandom());
    return w;
  endfunction

  // whole image is cleared first so no unwritten pixel is ever read or tested;
  // reads use the flipped row, which stays inside the cleared area
  task automatic clear_area(int cols, int rows);
    for (int r = 0; r < rows; r++)
      for (int c = 0; c < cols; c++)
        pending_words.push_back(make_word(OP_CLEAR, c, r));
  endtask

  // random words over a cols x rows image; a quarter land outside it
  task automatic random_words(int n, int cols, int rows);
    in_word_t w;
    int k;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(99);
      if (k < 55) w = make_word(OP_FRAGMENT, 0, 0);
      else if (k < 80) w = make_word(OP_READ, 0, 0);
      else if (k < 92) w = make_word(OP_CLEAR, 0, 0);
      else w = make_word(OP_UNUSED, 0, 0);
      if ($urandom_range(3) == 0) begin
        w.column = 9'($urandom());
        w.row = 9'($urandom());
        // an outside word must really be outside, never an unwritten pixel
        if (w.column < cols && w.row < rows) w.column = (cols < 512) ? 9'(cols) : 9'd511;
        if (w.column < cols && w.row < rows) w.row = (rows < 512) ? 9'(rows) : 9'd511;
        if (w.column < cols && w.row < rows) begin
          w.column = 9'($urandom_range(cols - 1));
          w.row = 9'($urandom_range(rows - 1));
        end
      end else begin
        w.column = 9'($urandom_range(cols - 1));
        w.row = 9'($urandom_range(rows - 1));
      end
      if ($urandom_range(7) == 0) w.distance = ($urandom_range(1)) ? 32'hFFFF_FFFF : 32'h0;
      if ($urandom_range(9) == 0) {w.normal_x, w.normal_y, w.normal_z} = '0;
      pending_words.push_back(w);
    end
  endtask

  initial begin
    in_word_t w;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: small image with the light and background registers at extremes
    write_reg(CFG_COLUMNS, 24'd4);
    write_reg(CFG_ROWS, 24'd3);
    write_reg(CFG_BACKGROUND, 24'hFFFFFF);
    write_reg(CFG_LIGHT_X, 24'h008000);
    write_reg(CFG_LIGHT_Y, 24'h007FFF);
    write_reg(CFG_LIGHT_Z, 24'h000000);
    clear_area(4, 3);
    w = make_word(OP_FRAGMENT, 3, 2); w.distance = '0;
    w.normal_x = 16'sh7FFF; w.normal_y = 16'sh8000; w.normal_z = 16'sh7FFF;
    {w.base_red, w.base_green, w.base_blue} = 24'hFF00FF;
    pending_words.push_back(w);
    w.distance = 32'hFFFF_FFFF; pending_words.push_back(w);
    w.normal_x = '0; w.normal_y = '0; w.normal_z = '0; w.column = '0; w.row = '0;
    w.distance = 32'hFFFF_FFFE; pending_words.push_back(w);
    pending_words.push_back(make_word(OP_READ, 3, 0));
    pending_words.push_back(make_word(OP_READ, 0, 2));
    pending_words.push_back(make_word(OP_READ, 4, 0));
    pending_words.push_back(make_word(OP_CLEAR, 0, 3));
    pending_words.push_back(make_word(OP_FRAGMENT, 511, 511));
    pending_words.push_back(make_word(OP_UNUSED, 1, 1));
    drain();

    // random phases over varied settings and idling
    for (int ph = 0; ph < 6; ph++) begin
      int cols, rows;
      cols = (ph == 5) ? 1 : $urandom_range(1, 12);
      rows = (ph == 4) ? 1 : $urandom_range(1, 12);
      idle_pct = (ph % 3 == 1) ? 73 : ((ph % 3 == 2) ? 11 : 0);
      write_reg(CFG_COLUMNS, 24'(cols));
      write_reg(CFG_ROWS, 24'(rows));
      write_reg(CFG_BACKGROUND, 24'($urandom()));
      write_reg(CFG_LIGHT_X, 24'($urandom()));
      write_reg(CFG_LIGHT_Y, 24'($urandom()));
      write_reg(CFG_LIGHT_Z, (ph == 0) ? 24'h004000 : 24'($urandom()));
      clear_area(cols, rows);
      random_words(150, cols, rows);
      drain();
    end

    // a few words across the full 512 x 512 image, sparse clears then hits
    write_reg(CFG_COLUMNS, 24'd512);
    write_reg(CFG_ROWS, 24'd512);
    idle_pct = 0;
    pending_words.push_back(make_word(OP_CLEAR, 511, 0));
    pending_words.push_back(make_word(OP_CLEAR, 0, 511));
    pending_words.push_back(make_word(OP_FRAGMENT, 511, 0));
    pending_words.push_back(make_word(OP_READ, 511, 511));
    pending_words.push_back(make_word(OP_READ, 0, 0));
    drain();

    if (errors == 0) $display("tb_zbuffer_shaded_fragment_writer_core passed");
    else $display("tb_zbuffer_shaded_fragment_writer_core failed");
    $finish;
  end

  // timeout, far beyond the slowest correct run
  initial begin
    #2000000;
    $display("tb_zbuffer_shaded_fragment_writer_core failed");
    $finish;
  end

endmodule
